### src/oikl_pkg.sv
`default_nettype none
package oikl_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SIN120_Q15    = 28378;
    localparam int HALF_Q15      = 16384;

    // projection and wheel widths
    localparam int WHL_W  = 19;
    // scaled magnitude width for the divider (max_abs <= 2^18)
    localparam int MAG_W  = 19;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_MAXSPD = 2'd1;
    localparam logic [1:0] REG_LIMEN  = 2'd2;
    localparam logic [1:0] REG_RPM    = 2'd3;

    typedef struct packed {
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] yaw_rate;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] wheel0_speed;
        logic signed [15:0] wheel1_speed;
        logic signed [15:0] wheel2_speed;
        logic signed [15:0] wheel0_rpm;
        logic signed [15:0] wheel1_rpm;
        logic signed [15:0] wheel2_rpm;
        logic               was_limited;
    } out_word_t;

    // classified command handed from front to back through the queue
    typedef struct packed {
        logic signed [WHL_W-1:0] w0;
        logic signed [WHL_W-1:0] w1;
        logic signed [WHL_W-1:0] w2;
        logic [MAG_W-1:0]        max_abs;
        logic                    do_scale;
    } cmd_t;

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        logic signed [15:0] r;
        if (v > 48'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -48'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### src/omni3_inverse_kinematics_limit_unit.sv
`default_nettype none
// Three-wheel omni inverse kinematics with speed limiting. One command word is
// accepted per cycle while s_ready is high and results leave in order, one per
// cycle while m_ready is high. The path runs through two front stages
// (projection, max search), the four-entry queue, then a back pipeline of
// 15+FRAC_BITS divider stages computing the scale ratio one quotient bit per
// stage, plus scale and rpm stages. Each pipeline stalls as a whole when its
// downstream is full; s_ready depends on the queue count and, with two entries
// queued, on m_ready in the same cycle. Configuration writes take effect at once,
// also on commands in flight, and are meant to be made only while the block is idle.
module omni3_inverse_kinematics_limit_unit #(
    parameter int FRAC_BITS = oikl_pkg::FRAC_BITS_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  oikl_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output oikl_pkg::out_word_t m_data,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire [1:0]           cfg_index,
    input  wire [23:0]          cfg_data
);
    localparam int QD = 4;

    logic [9:0]  radius_reg;
    logic [14:0] max_spd_reg;
    logic        lim_en_reg;
    logic [23:0] rpm_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg  <= 10'd100;
            max_spd_reg <= 15'd2000;
            lim_en_reg  <= 1'b1;
            rpm_reg     <= 24'd20861;
        end else if (cfg_valid) begin
            case (cfg_index)
                oikl_pkg::REG_RADIUS: radius_reg  <= cfg_data[9:0];
                oikl_pkg::REG_MAXSPD: max_spd_reg <= cfg_data[14:0];
                oikl_pkg::REG_LIMEN:  lim_en_reg  <= cfg_data[0];
                oikl_pkg::REG_RPM:    rpm_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // front: two stages; runs while queue has room for everything in flight
    logic           f_valid;
    oikl_pkg::cmd_t f_cmd;
    logic           q_empty, q_rd;
    oikl_pkg::cmd_t q_data;
    logic [$clog2(QD+1)-1:0] q_cnt;
    logic           f_en;
    logic           b_en, b_valid;
    logic           q_wr;

    assign f_en    = (q_cnt <= ($clog2(QD+1))'(QD-3)) || (q_cnt == ($clog2(QD+1))'(QD-2)
                     && q_rd);
    assign s_ready = f_en;
    assign q_wr    = f_en && f_valid;

    oikl_front u_front (
        .aclk(aclk), .aresetn(aresetn), .en(f_en),
        .in_valid(s_valid), .in_word(s_data),
        .radius(radius_reg), .max_spd(max_spd_reg), .lim_en(lim_en_reg),
        .out_valid(f_valid), .out_cmd(f_cmd)
    );

    oikl_fifo #(.DEPTH(QD)) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .wr_en(q_wr), .wr_data(f_cmd),
        .rd_en(q_rd), .rd_data(q_data),
        .empty(q_empty), .count(q_cnt)
    );

    // back advances when output slot is free or being taken
    assign b_en = !m_valid || m_ready;
    assign q_rd = b_en && !q_empty;

    oikl_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .en(b_en),
        .in_valid(!q_empty), .in_cmd(q_data),
        .max_spd(max_spd_reg), .rpm_q(rpm_reg),
        .out_valid(b_valid), .out_word(m_data)
    );
    assign m_valid = b_valid;
endmodule
`default_nettype wire

### src/oikl_front.sv
`default_nettype none
// projection, rotation term and max search, two stages
module oikl_front (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 en,
    input  wire                 in_valid,
    input  oikl_pkg::in_word_t  in_word,
    input  wire [9:0]           radius,
    input  wire [14:0]          max_spd,
    input  wire                 lim_en,
    output logic                out_valid,
    output oikl_pkg::cmd_t      out_cmd
);
    localparam int W = oikl_pkg::WHL_W;

    // stage 1: products
    logic               v1_reg;
    logic signed [31:0] px_reg, py_reg;
    logic signed [26:0] rp_reg;
    logic signed [15:0] vy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            px_reg <= 32'(signed'(in_word.vel_x)) * 32'sd28378;
            py_reg <= 32'(signed'(in_word.vel_y)) * 32'sd16384;
            rp_reg <= 27'(signed'(in_word.yaw_rate)) * signed'({17'd0, radius});
            vy_reg <= in_word.vel_y;
        end
    end

    // stage 2: truncating divides by constants
    logic signed [32:0] s1, s2;
    logic signed [32:0] a1, a2;
    logic signed [W-1:0] p1, p2, rot, w0, w1, w2;
    logic [W-1:0] m0, m1, m2, mx;
    logic [26:0] rmag;
    logic [26:0] rq;
    logic [55:0] rprod;
    oikl_pkg::cmd_t cmd_next;

    always_comb begin
        s1 = -33'(px_reg) - 33'(py_reg);
        s2 = 33'(px_reg) - 33'(py_reg);
        a1 = s1[32] ? -s1 : s1;
        a2 = s2[32] ? -s2 : s2;
        p1 = s1[32] ? -W'(a1 >>> 15) : W'(a1 >>> 15);
        p2 = s2[32] ? -W'(a2 >>> 15) : W'(a2 >>> 15);
        rmag = rp_reg[26] ? 27'(-rp_reg) : 27'(rp_reg);
        // /1000 via reciprocal: ceil(2^35/1000)=34359739, exact for 25-bit magnitudes
        rprod = 56'(rmag) * 56'd34359739;
        rq = 27'(rprod >> 35);
        rot = rp_reg[26] ? -W'(rq) : W'(rq);
        w0 = W'(vy_reg) + rot;
        w1 = p1 + rot;
        w2 = p2 + rot;
        m0 = w0[W-1] ? W'(-w0) : W'(w0);
        m1 = w1[W-1] ? W'(-w1) : W'(w1);
        m2 = w2[W-1] ? W'(-w2) : W'(w2);
        mx = m0;
        if (m1 > mx) mx = m1;
        if (m2 > mx) mx = m2;
        cmd_next.w0 = w0;
        cmd_next.w1 = w1;
        cmd_next.w2 = w2;
        cmd_next.max_abs = mx;
        cmd_next.do_scale = lim_en && (mx > W'(max_spd));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= v1_reg;
        end
        if (en) begin
            out_cmd <= cmd_next;
        end
    end
endmodule
`default_nettype wire

### src/oikl_fifo.sv
`default_nettype none
// short queue between front and back
module oikl_fifo #(
    parameter int DEPTH = 4
) (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             wr_en,
    input  oikl_pkg::cmd_t  wr_data,
    input  wire             rd_en,
    output oikl_pkg::cmd_t  rd_data,
    output logic            empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int AW = $clog2(DEPTH);
    oikl_pkg::cmd_t mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [$clog2(DEPTH+1)-1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (rd_en) rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (wr_en ? 1'b1 : 1'b0) - (rd_en ? 1'b1 : 1'b0);
        end
        if (wr_en) mem[wp_reg] <= wr_data;
    end

    assign rd_data = mem[rp_reg];
    assign empty   = (cnt_reg == '0);
    assign count   = cnt_reg;
endmodule
`default_nettype wire

### src/oikl_back.sv
`default_nettype none
// pipelined restoring divider, scaling, rpm conversion
module oikl_back #(
    parameter int FRAC_BITS = oikl_pkg::FRAC_BITS_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 en,
    input  wire                 in_valid,
    input  oikl_pkg::cmd_t      in_cmd,
    input  wire [14:0]          max_spd,
    input  wire [23:0]          rpm_q,
    output logic                out_valid,
    output oikl_pkg::out_word_t out_word
);
    localparam int W  = oikl_pkg::WHL_W;
    localparam int NW = 15 + FRAC_BITS;   // numerator width
    localparam int NS = NW;               // one quotient bit a stage

    logic           v_reg  [NS+1];
    oikl_pkg::cmd_t c_reg  [NS+1];
    logic [NW-1:0]  n_reg  [NS+1];
    logic [W:0]     r_reg  [NS+1];
    logic [NW-1:0]  q_reg  [NS+1];

    always_comb begin
        v_reg[0] = in_valid;
        c_reg[0] = in_cmd;
        n_reg[0] = {max_spd, FRAC_BITS'(0)};
        r_reg[0] = '0;
        q_reg[0] = '0;
    end

    for (genvar k = 0; k < NS; k++) begin : g_div
        logic [W:0] t;
        always_comb t = {r_reg[k][W-1:0], n_reg[k][NW-1-k]};
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_reg[k];
            end
            if (en) begin
                c_reg[k+1] <= c_reg[k];
                n_reg[k+1] <= n_reg[k];
                if (t >= {1'b0, c_reg[k].max_abs}) begin
                    r_reg[k+1] <= t - {1'b0, c_reg[k].max_abs};
                    q_reg[k+1] <= q_reg[k] | (NW'(1) << (NW-1-k));
                end else begin
                    r_reg[k+1] <= t;
                    q_reg[k+1] <= q_reg[k];
                end
            end
        end
    end

    // scale stage: quotient <= 2^FRAC_BITS when scaling applies
    oikl_pkg::cmd_t cd;
    logic [FRAC_BITS:0] sc;
    assign cd = c_reg[NS];
    assign sc = (FRAC_BITS+1)'(q_reg[NS]);

    function automatic logic signed [W-1:0] scl(input logic signed [W-1:0] w,
                                                  input logic [FRAC_BITS:0] s);
        logic [W-1:0] m;
        logic [W+FRAC_BITS:0] p;
        logic [W-1:0] r;
        m = w[W-1] ? W'(-w) : W'(w);
        p = (W+FRAC_BITS+1)'(m) * (W+FRAC_BITS+1)'(s);
        r = W'(p >> FRAC_BITS);
        return w[W-1] ? -signed'(r) : signed'(r);
    endfunction

    logic signed [W-1:0] ws [3];
    logic signed [15:0]  wt [3];
    logic                hit;
    logic                v_s_reg, lim_s_reg;
    logic signed [15:0]  w_s_reg [3];

    always_comb begin
        ws[0] = cd.do_scale ? scl(cd.w0, sc) : cd.w0;
        ws[1] = cd.do_scale ? scl(cd.w1, sc) : cd.w1;
        ws[2] = cd.do_scale ? scl(cd.w2, sc) : cd.w2;
        hit = cd.do_scale;
        for (int i = 0; i < 3; i++) begin
            wt[i] = oikl_pkg::sat16(48'(ws[i]));
            if (48'(wt[i]) != 48'(ws[i])) hit = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_s_reg <= 1'b0;
        end else if (en) begin
            v_s_reg <= v_reg[NS];
        end
        if (en) begin
            lim_s_reg <= hit;
            for (int i = 0; i < 3; i++) w_s_reg[i] <= wt[i];
        end
    end

    // rpm stage: 16x24 signed products, truncate toward zero
    logic signed [40:0] pr [3];
    logic signed [40:0] qr [3];
    logic signed [15:0] rr [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pr[i] = 41'(w_s_reg[i]) * signed'({17'd0, rpm_q});
            qr[i] = pr[i][40] ? -((-pr[i]) >>> FRAC_BITS) : (pr[i] >>> FRAC_BITS);
            rr[i] = oikl_pkg::sat16(48'(qr[i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= v_s_reg;
        end
        if (en) begin
            out_word.wheel0_speed <= w_s_reg[0];
            out_word.wheel1_speed <= w_s_reg[1];
            out_word.wheel2_speed <= w_s_reg[2];
            out_word.wheel0_rpm   <= rr[0];
            out_word.wheel1_rpm   <= rr[1];
            out_word.wheel2_rpm   <= rr[2];
            out_word.was_limited  <= lim_s_reg;
        end
    end
endmodule
`default_nettype wire

### src/oikl_checker.sv
`default_nettype none
module oikl_checker (
    input wire                 aclk,
    input wire                 aresetn,
    input wire                 s_ready,
    input wire                 m_valid,
    input wire                 m_ready,
    input oikl_pkg::out_word_t m_data,
    input wire                 cfg_ready
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("out hold");
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready) else $error("cfg not ready");
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid) else $error("valid after reset");
    a_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready) else $error("input stalled with idle output");
endmodule

bind omni3_inverse_kinematics_limit_unit oikl_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data), .cfg_ready(cfg_ready)
);
`default_nettype wire
